// ----- rtl/qacs_pkg.sv -----
// ----------------------------------------------------------------------------
// qacs_pkg
// shared widths, constants and the search stage payload for the quad scorer
// ----------------------------------------------------------------------------
package qacs_pkg;

  localparam int COORD_BITS = 8;
  localparam int FRAC_BITS  = 8;
  localparam int SCORE_BITS = 28;

  localparam int SUM_W  = COORD_BITS + 2;             // sum of four corners
  localparam int DIF_W  = COORD_BITS + 4;             // 4*c - sum, signed
  localparam int AREA_W = 2 * COORD_BITS + 4;         // doubled shoelace, signed
  localparam int MAG_W  = AREA_W;                     // magnitude of area
  localparam int D_W    = 2 * DIF_W - 1;              // dx^2 + dy^2
  localparam int N_W    = MAG_W + 1 + FRAC_BITS;      // 2*mag << frac
  localparam int N2_W   = 2 * N_W;                    // n^2
  localparam int Q_W    = SCORE_BITS;                 // searched quotient bits
  localparam int QIX_W  = $clog2(Q_W);
  localparam int ACC_W  = N2_W + Q_W + D_W;           // trial sum width

  localparam logic [SCORE_BITS-1:0] POS_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic [SCORE_BITS-1:0] NEG_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [ACC_W-1:0] p;     // q^2 * d
    logic [ACC_W-1:0] qd;    // q * d
    logic [D_W-1:0]   d;
    logic [N2_W-1:0]  n2;
    logic [Q_W-1:0]   q;
    logic             neg;
  } qacs_srch_t;

endpackage

// ----- rtl/quad_area_center_score.sv -----
// ----------------------------------------------------------------------------
// quad_area_center_score
// signed shoelace area of a quad over the distance of its centroid to the
// frame center, 8 fraction bits, truncated toward zero
// ----------------------------------------------------------------------------
//  channel  | ports                                   | dir
//  in       | in_valid, in_ready, in_corner0_x..3_y   | in
//  out      | out_valid, out_ready, out_score, out_at_center | out
//  cfg      | cfg_we, cfg_index, cfg_wdata            | in
//
//  one beat accepted per cycle while the output is not stalled, 3 + 28 + 1 = 32 register stages
//  most of those register stages are the 28 one-bit stages of the root-quotient search
//  rst_n clears all valid bits and loads width 160, height 120
//  a waiting output beat stalls the whole pipe; nothing is dropped or repeated
module quad_area_center_score (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner0_x,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner0_y,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner1_x,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner1_y,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner2_x,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner2_y,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner3_x,
  input  logic [qacs_pkg::COORD_BITS-1:0]       in_corner3_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [qacs_pkg::SCORE_BITS-1:0] out_score,
  output logic                                  out_at_center,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [qacs_pkg::COORD_BITS-1:0]       cfg_wdata
);

  localparam int CW  = qacs_pkg::COORD_BITS;
  localparam int QW  = qacs_pkg::Q_W;
  localparam int SB  = qacs_pkg::SCORE_BITS;

  // configuration
  logic [CW-1:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CW'(160);
      frame_height_r <= CW'(120);
    end else if (cfg_we) begin
      case (cfg_index)
        qacs_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        qacs_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the output beat is held
  logic adv;
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // stage a: sums and shoelace terms
  logic [CW-1:0] cx[4], cy[4];
  assign cx[0] = in_corner0_x; assign cy[0] = in_corner0_y;
  assign cx[1] = in_corner1_x; assign cy[1] = in_corner1_y;
  assign cx[2] = in_corner2_x; assign cy[2] = in_corner2_y;
  assign cx[3] = in_corner3_x; assign cy[3] = in_corner3_y;

  logic [qacs_pkg::SUM_W-1:0]         sum_x, sum_y;
  logic signed [qacs_pkg::AREA_W-1:0] area_nxt;
  logic signed [qacs_pkg::DIF_W-1:0]  dx_nxt, dy_nxt;

  always_comb begin
    logic signed [qacs_pkg::AREA_W-1:0] ddx, ssy;
    sum_x    = '0;
    sum_y    = '0;
    area_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sum_x = sum_x + qacs_pkg::SUM_W'(cx[i]);
      sum_y = sum_y + qacs_pkg::SUM_W'(cy[i]);
      ddx = $signed(qacs_pkg::AREA_W'(cx[(i + 1) % 4])) - $signed(qacs_pkg::AREA_W'(cx[i]));
      ssy = $signed(qacs_pkg::AREA_W'(cy[(i + 1) % 4])) + $signed(qacs_pkg::AREA_W'(cy[i]));
      area_nxt = area_nxt + qacs_pkg::AREA_W'(ddx * ssy);
    end
    // 4 * (size >> 1) - sum
    dx_nxt = $signed(qacs_pkg::DIF_W'({frame_width_r[CW-1:1], 2'b00}))
           - $signed(qacs_pkg::DIF_W'(sum_x));
    dy_nxt = $signed(qacs_pkg::DIF_W'({frame_height_r[CW-1:1], 2'b00}))
           - $signed(qacs_pkg::DIF_W'(sum_y));
  end

  logic                               va_r;
  logic signed [qacs_pkg::AREA_W-1:0] area_a_r;
  logic signed [qacs_pkg::DIF_W-1:0]  dx_a_r, dy_a_r;

  // stage b: distance squared, magnitude, scaled numerator
  logic                       vb_r;
  logic [qacs_pkg::D_W-1:0]   d_b_r;
  logic [qacs_pkg::N_W-1:0]   n_b_r;
  logic                       neg_b_r;
  logic [qacs_pkg::MAG_W-1:0] mag_b;
  logic [2*qacs_pkg::DIF_W-1:0] dx2, dy2;

  always_comb begin
    mag_b = area_a_r[qacs_pkg::AREA_W-1] ? qacs_pkg::MAG_W'(-area_a_r)
                                         : qacs_pkg::MAG_W'(area_a_r);
    // full-width signed squares
    dx2 = $unsigned((2*qacs_pkg::DIF_W)'(dx_a_r) * (2*qacs_pkg::DIF_W)'(dx_a_r));
    dy2 = $unsigned((2*qacs_pkg::DIF_W)'(dy_a_r) * (2*qacs_pkg::DIF_W)'(dy_a_r));
  end

  // stage c: n squared
  logic                 vc_r;
  qacs_pkg::qacs_srch_t srch_r[QW+1];
  logic                 vs_r[QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      area_a_r <= area_nxt;
      dx_a_r   <= dx_nxt;
      dy_a_r   <= dy_nxt;
      d_b_r    <= qacs_pkg::D_W'(dx2) + qacs_pkg::D_W'(dy2);
      n_b_r    <= qacs_pkg::N_W'({mag_b, 1'b0}) << qacs_pkg::FRAC_BITS;
      neg_b_r  <= area_a_r[qacs_pkg::AREA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (adv) begin
      vs_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srch_r[0].p   <= '0;
      srch_r[0].qd  <= '0;
      srch_r[0].d   <= d_b_r;
      srch_r[0].n2  <= qacs_pkg::N2_W'(n_b_r) * qacs_pkg::N2_W'(n_b_r);
      srch_r[0].q   <= '0;
      srch_r[0].neg <= neg_b_r;
    end
  end

  // search stages, most significant quotient bit first
  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_srch
      qacs_pkg::qacs_srch_t step_nxt;

      qacs_step u_step (
        .bit_idx (qacs_pkg::QIX_W'(QW - 1 - g)),
        .cur     (srch_r[g]),
        .nxt     (step_nxt)
      );

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vs_r[g+1] <= 1'b0;
        end else if (adv) begin
          vs_r[g+1] <= vs_r[g];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          srch_r[g+1] <= step_nxt;
        end
      end
    end
  endgenerate

  // output stage: clamp, sign, centroid-at-center saturation
  qacs_pkg::qacs_srch_t fin;
  logic [QW-1:0]        lim, q_clamp;
  logic [SB-1:0]        score_nxt;
  logic                 at_center_nxt;

  always_comb begin
    fin           = srch_r[QW];
    lim           = fin.neg ? QW'(qacs_pkg::NEG_MIN) : QW'(qacs_pkg::POS_MAX);
    q_clamp       = (fin.q > lim) ? lim : fin.q;
    at_center_nxt = (fin.d == '0);
    if (at_center_nxt) begin
      if (fin.neg)              score_nxt = qacs_pkg::NEG_MIN;
      else if (fin.n2 != '0)    score_nxt = qacs_pkg::POS_MAX;
      else                      score_nxt = '0;
    end else begin
      score_nxt = fin.neg ? SB'(-q_clamp) : SB'(q_clamp);
    end
  end

  logic          out_valid_r;
  logic [SB-1:0] out_score_r;
  logic          out_at_center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_score_r     <= score_nxt;
      out_at_center_r <= at_center_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_score     = $signed(out_score_r);
  assign out_at_center = out_at_center_r;

`ifndef SYNTH
  // centered quads only ever carry a saturated or zero score
  a_center_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_at_center) |-> (out_score_r == qacs_pkg::POS_MAX ||
      out_score_r == qacs_pkg::NEG_MIN || out_score_r == '0))
    else $error("at_center beat without saturated score");

  // a held output beat freezes the entry of the pipe too
  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output is stalled");

  // a stalled result beat keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_score_r) &&
      $stable(out_at_center_r)))
    else $error("stalled output beat changed");
`endif

endmodule

// ----- rtl/qacs_step.sv -----
// ----------------------------------------------------------------------------
// qacs_step
// one bit of the root-quotient search: largest q with q*q*d <= n*n
// ----------------------------------------------------------------------------
module qacs_step (
  input  logic [qacs_pkg::QIX_W-1:0] bit_idx,
  input  qacs_pkg::qacs_srch_t       cur,
  output qacs_pkg::qacs_srch_t       nxt
);

  logic [qacs_pkg::ACC_W-1:0] d_ext;
  logic [qacs_pkg::ACC_W-1:0] trial;
  logic                       take;

  always_comb begin
    d_ext = qacs_pkg::ACC_W'(cur.d);
    // (q + 2^k)^2 d = q^2 d + 2^(k+1) q d + 2^(2k) d
    trial = cur.p + (cur.qd << (bit_idx + 1'b1)) + (d_ext << (2 * bit_idx));
    take  = trial <= qacs_pkg::ACC_W'(cur.n2);
    nxt   = cur;
    if (take) begin
      nxt.p  = trial;
      nxt.qd = cur.qd + (d_ext << bit_idx);
      nxt.q  = cur.q | (qacs_pkg::Q_W'(1) << bit_idx);
    end
  end

endmodule
